>>> sv/bba_pkg.sv
package bba_pkg;

    localparam int UNITS_LOG2 = 8;
    localparam int UNITS      = 1 << UNITS_LOG2;
    localparam int ORD_W      = 4;
    localparam int ADDR_W     = 24;
    localparam int CNT_W      = UNITS_LOG2 + 1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_USED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LARGE   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic [1:0] REG_UNIT_SIZE = 2'd0;
    localparam logic [1:0] REG_REGION    = 2'd1;
    localparam logic [1:0] REG_MAX_REQ   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ORD_W-1:0] order;
    } map_ent_t;

    typedef struct packed {
        logic                  we;
        logic                  clear;
        logic [UNITS_LOG2-1:0] waddr;
        map_ent_t              wdata;
        logic [UNITS_LOG2-1:0] raddr;
    } map_req_t;

endpackage

>>> sv/bba_map.sv
module bba_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bba_pkg::map_req_t          req,
    input  logic [bba_pkg::ORD_W-1:0]  region_order,
    output bba_pkg::map_ent_t          rd
);
    import bba_pkg::*;

    map_ent_t         mem [UNITS];
    logic [UNITS-1:0] valid_reg;
    map_ent_t         rdata_reg;
    logic             rvalid_reg;
    logic             rzero_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            rzero_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[req.raddr];
            rzero_reg  <= (req.raddr == '0);
        end
    end

    // unwritten entries read as the initial map
    always_comb
    begin
        if (rvalid_reg)
        begin
            rd = rdata_reg;
        end
        else if (rzero_reg)
        begin
            rd.kind  = KIND_FREE;
            rd.order = region_order;
        end
        else
        begin
            rd = '0;
        end
    end

endmodule

>>> sv/buddy_block_allocator.sv
// buddy_block_allocator: binary buddy allocator over up to 256 minimum units
// config: apb-style port, reg 0 unit size log2, reg 1 region order (write
//   re-initialises the map to one free block), reg 2 largest request in bytes
// input word (in_valid/in_ready): action 0 allocate request_size bytes,
//   action 1 free the block at free_address
// output word (out_valid/out_ready): status, block_address, block_order
// one item at a time; in_ready is high only while the sequencer is idle
// the map lives in one single-port-read ram with a registered read, so each
//   unit inspected takes a read state and then a check state
// allocate: the scan stops early when an exact fit is found, else runs to the
//   end of the region and splits the smallest larger free block; refusals go
//   straight to the output
// free: marks the block free, then merges with its buddy level by level until
//   the buddy is not free at that order or the whole region is reached; a bad free is refused
// the sequencer returns to idle before the next word is taken
// a finished word waits in the output register while the next item is taken;
//   the sequencer stalls at its last step only if that register is still full
// reset: registers to 4 / 8 / 4096, map to one free block of the whole region
module buddy_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [23:0] request_size,
    input  logic [23:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [23:0] block_address,
    output logic [3:0]  block_order
);
    import bba_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CALC    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_CK = 4'd3;
    localparam logic [3:0] S_SPLIT   = 4'd4;
    localparam logic [3:0] S_ALLOC   = 4'd5;
    localparam logic [3:0] S_F_RD    = 4'd6;
    localparam logic [3:0] S_F_CK    = 4'd7;
    localparam logic [3:0] S_F_LOOP  = 4'd8;
    localparam logic [3:0] S_F_BCK   = 4'd9;
    localparam logic [3:0] S_F_MLO   = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [4:0]            usl_reg;
    logic [ORD_W-1:0]      region_reg;
    logic [24:0]           max_reg;
    logic [3:0]            state_reg, state_next;
    logic                  action_reg;
    logic [23:0]           size_reg, addr_reg;
    logic [ORD_W-1:0]      want_reg, want_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [UNITS_LOG2-1:0] best_reg, best_next;
    logic [ORD_W-1:0]      bo_reg, bo_next;
    logic                  big_reg, big_next;
    logic [UNITS_LOG2-1:0] u_reg, u_next;
    logic [ORD_W-1:0]      o_reg, o_next, ord_reg, ord_next;
    logic [1:0]            rs_reg, rs_next;
    logic [23:0]           ra_reg, ra_next;
    logic [ORD_W-1:0]      ro_reg, ro_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg;
    logic [23:0]           address_reg;
    logic [ORD_W-1:0]      order_reg;

    map_req_t              req;
    map_ent_t              rd;
    logic                  cfg_wr;
    logic [ORD_W-1:0]      want_raw;
    logic [5:0]            sh;
    logic [CNT_W-1:0]      n_units;
    logic [23:0]           unit;
    logic [UNITS_LOG2-1:0] bud, lo, hi;
    logic [ORD_W-1:0]      nord;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_UNIT_SIZE: prdata = {27'd0, usl_reg};
            REG_REGION:    prdata = {28'd0, region_reg};
            REG_MAX_REQ:   prdata = {7'd0, max_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usl_reg    <= 5'd4;
            region_reg <= ORD_W'(UNITS_LOG2);
            max_reg    <= 25'd4096;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_UNIT_SIZE: usl_reg <= pwdata[4:0];
                REG_REGION:    region_reg <= (pwdata[3:0] > ORD_W'(UNITS_LOG2)) ?
                                             ORD_W'(UNITS_LOG2) : pwdata[3:0];
                REG_MAX_REQ:   max_reg <= pwdata[24:0];
                default:       ;
            endcase
        end
    end

    // order of the request: lowest w whose block covers the size
    always_comb
    begin
        want_raw = '1;
        sh       = '0;
        for (int w = UNITS_LOG2; w >= 0; w--)
        begin
            sh = 6'(w) + 6'(usl_reg);
            if (sh >= 6'd25 || {1'b0, size_reg} <= (25'd1 << sh))
            begin
                want_raw = ORD_W'(w);
            end
        end
    end

    assign n_units = CNT_W'(1) << region_reg;
    assign unit    = addr_reg >> usl_reg;
    assign bud     = u_reg ^ (UNITS_LOG2'(1) << o_reg);
    assign lo      = (u_reg < bud) ? u_reg : bud;
    assign hi      = (u_reg < bud) ? bud : u_reg;
    assign nord    = bo_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        want_next      = want_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        bo_next        = bo_reg;
        big_next       = big_reg;
        u_next         = u_reg;
        o_next         = o_reg;
        ord_next       = ord_reg;
        rs_next        = rs_reg;
        ra_next        = ra_reg;
        ro_next        = ro_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req            = '0;
        req.clear      = cfg_wr && (paddr[3:2] == REG_REGION);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                rs_next = ST_OK;
                ra_next = '0;
                ro_next = '0;
                if (!action_reg)
                begin
                    cnt_next  = '0;
                    big_next  = 1'b0;
                    want_next = want_raw;
                    if ({1'b0, size_reg} > max_reg)
                    begin
                        rs_next    = ST_LARGE;
                        state_next = S_DONE;
                    end
                    else if (want_raw > region_reg)
                    begin
                        rs_next    = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if ((addr_reg & ~(24'hFFFFFF << usl_reg)) != '0 ||
                         {1'b0, unit} >= (25'd1 << region_reg))
                begin
                    rs_next    = ST_BADFREE;
                    ra_next    = addr_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    u_next     = unit[UNITS_LOG2-1:0];
                    state_next = S_F_RD;
                end
            end
            S_SCAN_RD:
            begin
                req.raddr  = cnt_reg[UNITS_LOG2-1:0];
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_SCAN_RD;
                if (rd.kind == KIND_FREE && rd.order == want_reg)
                begin
                    best_next  = cnt_reg[UNITS_LOG2-1:0];
                    state_next = S_ALLOC;
                end
                else
                begin
                    if (rd.kind == KIND_FREE && rd.order > want_reg &&
                        (!big_reg || rd.order <= bo_reg))
                    begin
                        big_next  = 1'b1;
                        bo_next   = rd.order;
                        best_next = cnt_reg[UNITS_LOG2-1:0];
                    end
                    if (cnt_reg + 1'b1 == n_units)
                    begin
                        if (big_next)
                        begin
                            state_next = S_SPLIT;
                        end
                        else
                        begin
                            rs_next    = ST_NOSPACE;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SPLIT:
            begin
                if (bo_reg > want_reg)
                begin
                    bo_next           = nord;
                    req.we            = 1'b1;
                    req.waddr         = best_reg + (UNITS_LOG2'(1) << nord);
                    req.wdata.kind    = KIND_FREE;
                    req.wdata.order   = nord;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                req.we          = 1'b1;
                req.waddr       = best_reg;
                req.wdata.kind  = KIND_USED;
                req.wdata.order = want_reg;
                ra_next         = 24'(best_reg) << usl_reg;
                ro_next         = want_reg;
                state_next      = S_DONE;
            end
            S_F_RD:
            begin
                req.raddr  = u_reg;
                state_next = S_F_CK;
            end
            S_F_CK:
            begin
                if (rd.kind != KIND_USED)
                begin
                    rs_next    = ST_BADFREE;
                    ra_next    = addr_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ord_next        = rd.order;
                    o_next          = rd.order;
                    req.we          = 1'b1;
                    req.waddr       = u_reg;
                    req.wdata.kind  = KIND_FREE;
                    req.wdata.order = rd.order;
                    state_next      = S_F_LOOP;
                end
            end
            S_F_LOOP:
            begin
                req.raddr = bud;
                if (o_reg < region_reg)
                begin
                    state_next = S_F_BCK;
                end
                else
                begin
                    ra_next    = addr_reg;
                    ro_next    = ord_reg;
                    state_next = S_DONE;
                end
            end
            S_F_BCK:
            begin
                if (rd.kind != KIND_FREE || rd.order != o_reg)
                begin
                    ra_next    = addr_reg;
                    ro_next    = ord_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    req.we     = 1'b1;
                    req.waddr  = hi;
                    u_next     = lo;
                    state_next = S_F_MLO;
                end
            end
            S_F_MLO:
            begin
                req.we          = 1'b1;
                req.waddr       = u_reg;
                req.wdata.kind  = KIND_FREE;
                req.wdata.order = o_reg + 1'b1;
                o_next          = o_reg + 1'b1;
                state_next      = S_F_LOOP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            big_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            big_reg       <= big_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            size_reg   <= request_size;
            addr_reg   <= free_address;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            status_reg  <= rs_reg;
            address_reg <= ra_reg;
            order_reg   <= ro_reg;
        end
        want_reg <= want_next;
        best_reg <= best_next;
        bo_reg   <= bo_next;
        u_reg    <= u_next;
        o_reg    <= o_next;
        ord_reg  <= ord_next;
        rs_reg   <= rs_next;
        ra_reg   <= ra_next;
        ro_reg   <= ro_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_address = address_reg;
    assign block_order   = order_reg;

    bba_map u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .region_order (region_reg),
        .rd           (rd)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_LARGE || status == ST_NOSPACE)
        |-> block_address == '0 && block_order == '0)
        else $error("refused request carries a block");

    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> bo_reg >= want_reg)
        else $error("split went below requested order");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CALC && !in_ready)
        else $error("item taken without starting the sequencer");
`endif

endmodule
